// File: sv/clex_pkg.sv
// Shared types, constants and character classes for the C subset lexer.
// No dependencies; every other file of the block imports this package.
package clex_pkg;

    // Field widths
    localparam int POS_BITS     = 16;
    localparam int VALUE_BITS   = 32;
    localparam int KW_MAX_CHARS = 6;
    localparam int PUNCT_BITS   = 16;
    localparam int KW_ID_BITS   = 3;

    // Token queue between scanner and emitter
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Characters with a role of their own
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;

    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_KEYWORD = 3'd2,
        KIND_PUNCT   = 3'd3,
        KIND_END     = 3'd4,
        KIND_INVALID = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_PUNCT,
        MODE_ERR
    } scan_mode_t;

    // Keyword identifiers
    localparam logic [KW_ID_BITS-1:0] KW_RETURN = 3'd0;
    localparam logic [KW_ID_BITS-1:0] KW_IF     = 3'd1;
    localparam logic [KW_ID_BITS-1:0] KW_ELSE   = 3'd2;
    localparam logic [KW_ID_BITS-1:0] KW_FOR    = 3'd3;
    localparam logic [KW_ID_BITS-1:0] KW_WHILE  = 3'd4;
    localparam logic [KW_ID_BITS-1:0] KW_INT    = 3'd5;
    localparam logic [KW_ID_BITS-1:0] KW_NONE   = 3'd6;

    localparam int KW_COUNT      = 6;
    localparam int KW_TEXT_CHARS = 6;

    // Keyword spelling, first character at index 0, zero padded
    typedef logic [0:KW_TEXT_CHARS-1][7:0] kw_text_t;
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        "return",
        {"if",    32'h0},
        {"else",  16'h0},
        {"for",   24'h0},
        {"while",  8'h0},
        {"int",   24'h0}
    };
    localparam int KW_LEN [KW_COUNT] = '{6, 2, 4, 3, 5, 3};

    // Leading identifier characters, character j at index j
    typedef logic [KW_MAX_CHARS-1:0][7:0] kw_prefix_t;

    typedef struct packed {
        kind_t                   kind;
        logic [POS_BITS-1:0]     start_pos;
        logic [POS_BITS-1:0]     token_len;
        logic [VALUE_BITS-1:0]   num_value;
        logic [PUNCT_BITS-1:0]   punct_bytes;
        logic [KW_ID_BITS-1:0]   keyword_id;
        logic                    run_last;
    } token_t;

    // Up to two tokens caused by one byte
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } tok_pair_t;

    function automatic logic is_space(logic [7:0] b);
        return b inside {[8'd9:8'd13], 8'd32};
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_first(logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    endfunction

    function automatic logic is_next(logic [7:0] b);
        return is_first(b) || is_digit(b);
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        return b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
    endfunction

    function automatic logic is_pair_start(logic [7:0] b);
        return b inside {CH_EQ, CH_BANG, CH_GT, CH_LT};
    endfunction

    // Match the stored prefix and length against the keyword list
    function automatic logic [KW_ID_BITS-1:0] keyword_of(kw_prefix_t prefix,
                                                         logic [POS_BITS-1:0] len);
        logic [KW_ID_BITS-1:0] id;
        logic                  match;
        logic [7:0]            expect_ch;
        id = KW_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            match = (len == POS_BITS'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX_CHARS; j++)
            begin
                expect_ch = (j < KW_TEXT_CHARS) ? KW_TEXT[k][j] : 8'h00;
                if (prefix[j] != expect_ch)
                    match = 1'b0;
            end
            if (match)
                id = KW_ID_BITS'(k);
        end
        return id;
    endfunction

endpackage

// File: sv/clex_if.sv
// Handshake channels of the lexer: source text in, tokens out.
// Depends on clex_pkg for the field widths.
interface clex_text_if import clex_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface clex_token_if import clex_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            kind;
    logic [POS_BITS-1:0]   start_pos;
    logic [POS_BITS-1:0]   token_len;
    logic [VALUE_BITS-1:0] num_value;
    logic [PUNCT_BITS-1:0] punct_bytes;
    logic [KW_ID_BITS-1:0] keyword_id;
    logic                  run_last;

    modport source (output valid, output kind, output start_pos, output token_len,
                    output num_value, output punct_bytes, output keyword_id,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input start_pos, input token_len,
                    input num_value, input punct_bytes, input keyword_id,
                    input run_last, output ready);
endinterface

// File: sv/clex_scan.sv
// Front end: takes one text byte per transfer, tracks the token in progress
// and forms the zero, one or two tokens that the byte causes. Uses clex_pkg.
module clex_scan import clex_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    clex_text_if.sink    text,
    output logic         wr_valid,
    input  logic         wr_ready,
    output tok_pair_t    wr_data
);

    scan_mode_t              mode_reg,     mode_next;
    logic [POS_BITS-1:0]     position_reg, position_next;
    logic [POS_BITS-1:0]     start_reg,    start_next;
    logic [POS_BITS-1:0]     length_reg,   length_next;
    logic [VALUE_BITS-1:0]   accum_reg,    accum_next;
    kw_prefix_t              prefix_reg,   prefix_next;
    logic [7:0]              punct_reg,    punct_next;

    logic [7:0]              b;
    logic                    accept;
    logic                    is_term;
    logic                    cont_num;
    logic                    cont_ident;
    logic [POS_BITS-1:0]     length_inc;
    logic [VALUE_BITS+3:0]   acc_wide;
    logic [VALUE_BITS-1:0]   acc_step;
    logic                    flush_avail;
    logic                    use_flush;
    logic                    new_valid;
    token_t                  blank_rec;
    token_t                  flush_rec;
    token_t                  new_rec;

    assign b          = text.text_byte;
    assign accept     = text.valid && text.ready;
    assign is_term    = (b == CH_NUL);
    assign cont_num   = (mode_reg == MODE_NUM) && is_digit(b);
    assign cont_ident = (mode_reg == MODE_IDENT) && is_next(b);
    assign text.ready = wr_ready;

    // Saturating length and decimal accumulate (times ten as shift and add)
    assign length_inc = (length_reg == '1) ? length_reg : length_reg + 1'b1;
    assign acc_wide   = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                      + (VALUE_BITS + 4)'(b[3:0]);
    assign acc_step   = (|acc_wide[VALUE_BITS+3:VALUE_BITS]) ? '1
                                                             : acc_wide[VALUE_BITS-1:0];

    // Token held in the scanner, as it would be reported now
    always_comb
    begin
        blank_rec             = '0;
        blank_rec.kind        = KIND_NUMBER;
        blank_rec.keyword_id  = KW_NONE;
        flush_rec             = blank_rec;
        flush_rec.start_pos   = start_reg;
        flush_rec.token_len   = length_reg;
        flush_avail           = 1'b1;
        case (mode_reg)
            MODE_NUM:
            begin
                flush_rec.kind      = KIND_NUMBER;
                flush_rec.num_value = accum_reg;
            end
            MODE_IDENT:
            begin
                flush_rec.keyword_id = keyword_of(prefix_reg, length_reg);
                flush_rec.kind       = (flush_rec.keyword_id == KW_NONE) ? KIND_IDENT
                                                                         : KIND_KEYWORD;
            end
            MODE_PUNCT:
            begin
                flush_rec.kind        = KIND_PUNCT;
                flush_rec.token_len   = POS_BITS'(1);
                flush_rec.punct_bytes = {8'h00, punct_reg};
            end
            default:
                flush_avail = 1'b0;
        endcase
    end

    // Tokens caused by the byte on the input
    always_comb
    begin
        use_flush = 1'b0;
        new_valid = 1'b0;
        new_rec   = blank_rec;
        new_rec.start_pos = position_reg;
        if (is_term)
        begin
            use_flush         = flush_avail;
            new_valid         = 1'b1;
            new_rec.kind      = KIND_END;
        end
        else if (mode_reg == MODE_ERR)
        begin
            new_valid = 1'b0;
        end
        else if (mode_reg == MODE_PUNCT && b == CH_EQ)
        begin
            new_valid           = 1'b1;
            new_rec.kind        = KIND_PUNCT;
            new_rec.start_pos   = start_reg;
            new_rec.token_len   = POS_BITS'(2);
            new_rec.punct_bytes = {CH_EQ, punct_reg};
        end
        else if (!cont_num && !cont_ident)
        begin
            use_flush = flush_avail;
            if (is_space(b) || is_digit(b) || is_first(b))
            begin
                new_valid = 1'b0;
            end
            else if (is_punct(b))
            begin
                new_valid           = !is_pair_start(b);
                new_rec.kind        = KIND_PUNCT;
                new_rec.token_len   = POS_BITS'(1);
                new_rec.punct_bytes = {8'h00, b};
            end
            else
            begin
                new_valid         = 1'b1;
                new_rec.kind      = KIND_INVALID;
                new_rec.token_len = POS_BITS'(1);
            end
        end
    end

    // Pack the results into one queue entry
    always_comb
    begin
        wr_valid                = text.valid && (use_flush || new_valid);
        wr_data.two             = use_flush && new_valid;
        wr_data.first           = use_flush ? flush_rec : new_rec;
        wr_data.first.run_last  = !(use_flush && new_valid);
        wr_data.second          = new_rec;
        wr_data.second.run_last = 1'b1;
    end

    // Next scanner state
    always_comb
    begin
        mode_next     = mode_reg;
        position_next = position_reg;
        start_next    = start_reg;
        length_next   = length_reg;
        accum_next    = accum_reg;
        prefix_next   = prefix_reg;
        punct_next    = punct_reg;
        if (accept)
        begin
            if (is_term)
            begin
                mode_next     = MODE_IDLE;
                position_next = '0;
                start_next    = '0;
                length_next   = '0;
                accum_next    = '0;
                prefix_next   = '0;
                punct_next    = '0;
            end
            else
            begin
                position_next = position_reg + 1'b1;
                if (mode_reg == MODE_ERR)
                begin
                    mode_next = MODE_ERR;
                end
                else if (mode_reg == MODE_PUNCT && b == CH_EQ)
                begin
                    mode_next  = MODE_IDLE;
                    punct_next = '0;
                end
                else if (cont_num)
                begin
                    accum_next  = acc_step;
                    length_next = length_inc;
                end
                else if (cont_ident)
                begin
                    for (int j = 0; j < KW_MAX_CHARS; j++)
                    begin
                        if (length_reg == POS_BITS'(j))
                            prefix_next[j] = b;
                    end
                    length_next = length_inc;
                end
                else
                begin
                    mode_next  = MODE_IDLE;
                    punct_next = '0;
                    if (is_space(b))
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_digit(b))
                    begin
                        mode_next   = MODE_NUM;
                        start_next  = position_reg;
                        length_next = POS_BITS'(1);
                        accum_next  = VALUE_BITS'(b[3:0]);
                    end
                    else if (is_first(b))
                    begin
                        mode_next      = MODE_IDENT;
                        start_next     = position_reg;
                        length_next    = POS_BITS'(1);
                        prefix_next    = '0;
                        prefix_next[0] = b;
                    end
                    else if (is_punct(b))
                    begin
                        if (is_pair_start(b))
                        begin
                            mode_next  = MODE_PUNCT;
                            punct_next = b;
                            start_next = position_reg;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_ERR;
                    end
                end
            end
        end
    end

    // Hold scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            position_reg <= '0;
            start_reg    <= '0;
            length_reg   <= '0;
            accum_reg    <= '0;
            prefix_reg   <= '0;
            punct_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            position_reg <= position_next;
            start_reg    <= start_next;
            length_reg   <= length_next;
            accum_reg    <= accum_next;
            prefix_reg   <= prefix_next;
            punct_reg    <= punct_next;
        end
    end

    // A terminator returns the scanner to the start of a fresh text
    a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_term) |=> (mode_reg == MODE_IDLE && position_reg == '0))
        else $error("scanner not idle after terminator");

    // A pending two-byte candidate always has its first character stored
    a_punct_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PUNCT) |-> (punct_reg != 8'h00))
        else $error("pending punctuator lost");

    // Nothing is queued for a byte in the ignoring state
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERR && !is_term) |-> !wr_valid)
        else $error("token produced while ignoring input");

endmodule

// File: sv/clex_fifo.sv
// Short queue of token pairs between the scanner and the emitter.
// Uses clex_pkg for the entry type and depth.
module clex_fifo import clex_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  tok_pair_t  wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output tok_pair_t  rd_data
);

    tok_pair_t               store_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg,  count_next;
    logic                    push;
    logic                    pop;

    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? FIFO_PTR_W'((wr_ptr_reg + 1'b1) % FIFO_DEPTH) : wr_ptr_reg;
        rd_ptr_next = pop  ? FIFO_PTR_W'((rd_ptr_reg + 1'b1) % FIFO_DEPTH) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue overfilled");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count wrong after read");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// File: sv/clex_emit.sv
// Back end: unpacks queued token pairs and presents one token per transfer
// from an output register. Uses clex_pkg and the token channel interface.
module clex_emit import clex_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_valid,
    output logic          rd_ready,
    input  tok_pair_t     rd_data,
    clex_token_if.source  tokens
);

    logic    out_valid_reg,  out_valid_next;
    logic    hold_valid_reg, hold_valid_next;
    token_t  out_rec_reg,    out_rec_next;
    token_t  hold_rec_reg,   hold_rec_next;
    logic    load;

    assign load     = !out_valid_reg || tokens.ready;
    assign rd_ready = load && !hold_valid_reg;

    // Refill the output register: second token of a pair first, then the queue
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_rec_next    = out_rec_reg;
        hold_rec_next   = hold_rec_reg;
        if (load)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = hold_rec_reg;
                hold_valid_next = 1'b0;
            end
            else if (rd_valid)
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = rd_data.first;
                hold_rec_next   = rd_data.second;
                hold_valid_next = rd_data.two;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        hold_rec_reg <= hold_rec_next;
    end

    // Drive the token channel
    assign tokens.valid       = out_valid_reg;
    assign tokens.kind        = out_rec_reg.kind;
    assign tokens.start_pos   = out_rec_reg.start_pos;
    assign tokens.token_len   = out_rec_reg.token_len;
    assign tokens.num_value   = out_rec_reg.num_value;
    assign tokens.punct_bytes = out_rec_reg.punct_bytes;
    assign tokens.keyword_id  = out_rec_reg.keyword_id;
    assign tokens.run_last    = out_rec_reg.run_last;

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("second token held with no token on output");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hold_valid_reg) |-> !out_rec_reg.run_last)
        else $error("first token of a pair marked last");

    a_held_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> hold_rec_reg.run_last)
        else $error("second token of a pair not marked last");

endmodule

// File: sv/c_subset_lexer.sv
// Top level of the C subset lexer: scanner, token queue and emitter.
// Depends on clex_pkg, clex_if, clex_scan, clex_fifo and clex_emit.
//
//  channel  | direction | payload                                  | transfer
//  ---------+-----------+------------------------------------------+------------------
//  text     | in        | text_byte                                | valid & ready
//  tokens   | out       | kind, start_pos, token_len, num_value,   | valid & ready
//           |           | punct_bytes, keyword_id, run_last        |
//
// One text byte is taken per cycle while the queue has room, and the scanner
// classifies it in the same cycle. A byte that closes one token and starts or
// ends another yields two tokens; the emitter sends one token per cycle while
// tokens.ready is high, so a run of such bytes slows input to the output rate
// once the four-entry queue fills. Tokens pass the queue, then the output register.
// Reset clears scanner state, queue and output valid; no clearing pass is needed.
// text.ready falls only while the queue is full; tokens.ready low stalls the queue.
module c_subset_lexer import clex_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    clex_text_if.sink     text,
    clex_token_if.source  tokens
);

    logic       wr_valid;
    logic       wr_ready;
    tok_pair_t  wr_data;
    logic       rd_valid;
    logic       rd_ready;
    tok_pair_t  rd_data;

    clex_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    clex_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    clex_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data),
        .tokens   (tokens)
    );

endmodule
